// ----- rtl/fcar_pkg.sv -----
// Package for the framed command reporter: widths, character codes, reply
// descriptor type and the reply text lookup. No dependencies.
package fcar_pkg;

	localparam int CMD_LEN    = 8;
	localparam int WPOS_W     = $clog2(CMD_LEN);
	localparam int BYTE_W     = 8;
	localparam int SAMPLE_W   = 12;
	localparam int HUND_W     = 9;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int RQ_DEPTH   = 2;
	localparam int RQ_PTR_W   = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
	localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);
	localparam int IDX_W      = 4;

	localparam logic [TICK_W-1:0] FIRST_DELAY_RST = 16'd1;
	localparam logic [TICK_W-1:0] REPEAT_RST      = 16'd300;
	localparam int                HUND_SCALE      = 500;

	// Item kinds.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 1'b1;

	// Character codes.
	localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
	localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
	localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
	localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
	localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
	localparam logic [BYTE_W-1:0] CH_T    = 8'h54;
	localparam logic [BYTE_W-1:0] CH_O    = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_K    = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
	localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
	localparam logic [BYTE_W-1:0] CH_C    = 8'h43;
	localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

	localparam logic [IDX_W-1:0] STOP_LAST = 4'd6;
	localparam logic [IDX_W-1:0] ADC_LAST  = 4'd11;

	typedef enum logic {
		REPLY_STOP = 1'b0,
		REPLY_ADC  = 1'b1
	} reply_kind_t;

	// One queued reply. The report value is split into its hundreds digit
	// and the remaining hundredths (0..99).
	typedef struct packed {
		reply_kind_t kind;
		logic [2:0]  hund;
		logic [6:0]  frac;
	} reply_desc_t;

	function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] d);
		return CH_ZERO + {4'd0, d};
	endfunction

	// Byte at position idx of a reply.
	function automatic logic [BYTE_W-1:0] reply_char(
		input reply_kind_t kind,
		input logic [IDX_W-1:0] idx,
		input logic [2:0] hund,
		input logic [3:0] tens,
		input logic [3:0] ones
	);
		logic [BYTE_W-1:0] c;
		c = CH_NUL;
		if (kind == REPLY_STOP) begin
			unique case (idx)
				4'd0: c = CH_S;
				4'd1: c = CH_T;
				4'd2: c = CH_O;
				4'd3: c = CH_P;
				4'd4: c = CH_HASH;
				4'd5: c = CH_CR;
				4'd6: c = CH_LF;
				default: c = CH_NUL;
			endcase
		end else begin
			unique case (idx)
				4'd0: c = CH_BANG;
				4'd1: c = CH_A;
				4'd2: c = CH_D;
				4'd3: c = CH_C;
				4'd4: c = CH_EQ;
				4'd5: c = digit_char({1'b0, hund});
				4'd6: c = CH_DOT;
				4'd7: c = digit_char(tens);
				4'd8: c = digit_char(ones);
				4'd9: c = CH_HASH;
				4'd10: c = CH_CR;
				4'd11: c = CH_LF;
				default: c = CH_NUL;
			endcase
		end
		return c;
	endfunction

endpackage

// ----- rtl/fcar_item_if.sv -----
// Input item channel of the framed command reporter.
// Depends on fcar_pkg.
interface fcar_item_if;
	import fcar_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] rx_byte;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source (output valid, cmd, rx_byte, adc_sample, input ready);
	modport sink   (input valid, cmd, rx_byte, adc_sample, output ready);
endinterface

// ----- rtl/fcar_tx_if.sv -----
// Reply byte channel of the framed command reporter.
// Depends on fcar_pkg.
interface fcar_tx_if;
	import fcar_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] tx_byte;
	logic              tx_last;

	modport source (output valid, tx_byte, tx_last, input ready);
	modport sink   (input valid, tx_byte, tx_last, output ready);
endinterface

// ----- rtl/fcar_cfg_if.sv -----
// Configuration write channel of the framed command reporter.
// Depends on fcar_pkg.
interface fcar_cfg_if;
	import fcar_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/fcar_front.sv -----
// Front part: accepts items, parses frames, keeps the countdown and decides
// which reply, if any, an item causes. Depends on fcar_pkg and the interfaces.
module fcar_front (
	input  logic                 clk,
	input  logic                 arst_n,
	fcar_item_if.sink            items,
	fcar_cfg_if.sink             cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output fcar_pkg::reply_desc_t push_desc
);
	import fcar_pkg::*;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'b001,
		PH_READ   = 3'b010,
		PH_DECIDE = 3'b100
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [BYTE_W-1:0]   text_q [CMD_LEN];
	logic [BYTE_W-1:0]   text_n [CMD_LEN];
	logic [WPOS_W-1:0]   wpos_q, wpos_n;
	logic                mode_q, mode_n;
	logic                lock_q, lock_n;
	logic [HUND_W-1:0]   held_q, held_n;
	logic [TICK_W-1:0]   ticks_q, ticks_n;
	logic                pend_q, pend_n;
	logic [TICK_W-1:0]   first_delay_q;
	logic [TICK_W-1:0]   repeat_q;

	logic                accept;
	logic                is_rst, is_ok;
	logic                send_stop, send_adc;
	logic [SAMPLE_W+HUND_W-1:0] scaled;
	logic [2:0]          hund;
	logic [HUND_W-1:0]   frac_w;

	assign accept      = items.valid && items.ready;
	assign items.ready = push_ready;
	assign cfg.ready   = 1'b1;

	assign is_rst = (text_q[0] == CH_R) && (text_q[1] == CH_S) &&
		(text_q[2] == CH_T) && (text_q[3] == CH_NUL);
	assign is_ok  = (text_q[0] == CH_O) && (text_q[1] == CH_K) &&
		(text_q[2] == CH_NUL);

	assign scaled = (SAMPLE_W+HUND_W)'(items.adc_sample) *
		(SAMPLE_W+HUND_W)'(HUND_SCALE);

	always_comb begin
		phase_n   = phase_q;
		text_n    = text_q;
		wpos_n    = wpos_q;
		mode_n    = mode_q;
		lock_n    = lock_q;
		held_n    = held_q;
		ticks_n   = ticks_q;
		pend_n    = pend_q;
		send_stop = 1'b0;
		send_adc  = 1'b0;
		if (accept) begin
			if (items.cmd == CMD_BYTE) begin
				unique case (phase_q)
					PH_WAIT: begin
						if (items.rx_byte == CH_BANG) phase_n = PH_READ;
					end
					PH_READ: begin
						if (items.rx_byte == CH_HASH) begin
							phase_n = PH_DECIDE;
							wpos_n  = '0;
						end else if (items.rx_byte != CH_BANG) begin
							text_n[wpos_q] = items.rx_byte;
							wpos_n = (wpos_q == WPOS_W'(CMD_LEN - 1)) ? '0 : wpos_q + 1'b1;
						end
					end
					PH_DECIDE: begin
						if (is_rst) begin
							mode_n = 1'b1;
							if (!lock_q) begin
								held_n = scaled[SAMPLE_W +: HUND_W];
								lock_n = 1'b1;
							end
							ticks_n = first_delay_q;
							pend_n  = 1'b0;
						end else if (is_ok) begin
							mode_n    = 1'b0;
							lock_n    = 1'b0;
							send_stop = 1'b1;
						end
						for (int i = 0; i < CMD_LEN; i++) text_n[i] = CH_NUL;
						phase_n = PH_WAIT;
					end
					default: phase_n = PH_WAIT;
				endcase
			end else if (ticks_q != '0) begin
				ticks_n = ticks_q - 1'b1;
				if (ticks_q == TICK_W'(1)) pend_n = 1'b1;
			end
			// A report goes out on any step that leaves an expiry pending
			// while reporting; the held value cannot change on such a step.
			if (!send_stop && mode_n && pend_n) begin
				send_adc = 1'b1;
				ticks_n  = repeat_q;
				pend_n   = 1'b0;
			end
		end
	end

	// Hundreds digit and remainder of the held value (0..499).
	always_comb begin
		if (held_q >= HUND_W'(400)) hund = 3'd4;
		else if (held_q >= HUND_W'(300)) hund = 3'd3;
		else if (held_q >= HUND_W'(200)) hund = 3'd2;
		else if (held_q >= HUND_W'(100)) hund = 3'd1;
		else hund = 3'd0;
		frac_w = held_q - HUND_W'(hund) * HUND_W'(100);
	end

	assign push_valid     = send_stop || send_adc;
	assign push_desc.kind = send_adc ? REPLY_ADC : REPLY_STOP;
	assign push_desc.hund = hund;
	assign push_desc.frac = frac_w[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			for (int i = 0; i < CMD_LEN; i++) text_q[i] <= CH_NUL;
			wpos_q        <= '0;
			mode_q        <= 1'b0;
			lock_q        <= 1'b0;
			held_q        <= '0;
			ticks_q       <= '0;
			pend_q        <= 1'b0;
			first_delay_q <= FIRST_DELAY_RST;
			repeat_q      <= REPEAT_RST;
		end else begin
			phase_q <= phase_n;
			text_q  <= text_n;
			wpos_q  <= wpos_n;
			mode_q  <= mode_n;
			lock_q  <= lock_n;
			held_q  <= held_n;
			ticks_q <= ticks_n;
			pend_q  <= pend_n;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_FIRST_DELAY: first_delay_q <= cfg.data;
					CFG_REPEAT:      repeat_q      <= cfg.data;
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- rtl/fcar_queue.sv -----
// Short queue of reply descriptors between front and back parts.
// Depends on fcar_pkg.
module fcar_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  fcar_pkg::reply_desc_t push_desc,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output fcar_pkg::reply_desc_t pop_desc
);
	import fcar_pkg::*;

	reply_desc_t           slot_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_q, rd_q;
	logic [RQ_CNT_W-1:0]   cnt_q;
	logic                  do_push, do_pop;

	assign push_ready = (cnt_q != RQ_CNT_W'(RQ_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_desc   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ----- rtl/fcar_back.sv -----
// Back part: takes reply descriptors from the queue and sends their text
// one byte per transfer. Depends on fcar_pkg and fcar_tx_if.
module fcar_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  fcar_pkg::reply_desc_t pop_desc,
	fcar_tx_if.source             reply
);
	import fcar_pkg::*;

	logic              busy_q;
	reply_kind_t       kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [2:0]        hund_q;
	logic [3:0]        tens_q, ones_q;

	logic              last;
	logic              sent;
	logic [14:0]       tens_prod;
	logic [3:0]        tens;
	logic [6:0]        ones_w;

	assign last = (kind_q == REPLY_STOP) ? (idx_q == STOP_LAST) : (idx_q == ADC_LAST);
	assign sent = reply.valid && reply.ready;

	// Next descriptor is taken when idle or as the final byte leaves.
	assign pop_ready = !busy_q || (sent && last);

	// Tens digit of a value below 100 by reciprocal multiply (x*205 >> 11).
	assign tens_prod = 15'(pop_desc.frac) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign ones_w    = pop_desc.frac - 7'(tens) * 7'd10;

	assign reply.valid   = busy_q;
	assign reply.tx_byte = reply_char(kind_q, idx_q, hund_q, tens_q, ones_q);
	assign reply.tx_last = last;

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			kind_q <= pop_desc.kind;
			hund_q <= pop_desc.hund;
			tens_q <= tens;
			ones_q <= ones_w[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (sent && last) begin
				busy_q <= 1'b0;
			end else if (sent) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end
endmodule

// ----- rtl/framed_command_adc_reporter_unit.sv -----
// Top level of the framed command reporter: front parser, reply queue and
// byte sender. Depends on fcar_pkg, the channel interfaces and the submodules.
//
// The unit reads a stream of items, each either a received serial byte or a
// timer tick, and answers on a byte stream. A command frame opens with '!'
// and closes with '#'; the bytes in between fill an eight-byte command buffer
// whose write position wraps. The byte after '#' is swallowed and the buffer
// is then checked against "RST" and "OK" as a zero-terminated string and
// cleared. RST latches the converter reading (unless one is already locked)
// as hundredths of a volt and starts a countdown of first_delay_ticks ticks;
// each expiry sends "!ADC=d.dd#\r\n" and reloads repeat_ticks. OK unlocks the
// reading, stops reporting and sends "STOP#\r\n". Every reply byte is its own
// transfer on the reply channel, and tx_last marks the final byte of a reply.
// Timing: the front takes one item per clock as long as the reply queue has
// room; an item is processed in the cycle of its transfer. The reply queue
// holds two replies. The back sends one byte per clock while the reply
// channel is ready; a reply is seven (STOP) or twelve (report) bytes, and
// its descriptor is registered in the queue and then in the back before
// its first byte appears, so the byte sender sets the sustained rate. The
// two configuration registers (index 0 first delay, index 1 repeat interval)
// are written through the cfg channel, which is always ready; the user must
// write them only while the unit is idle, which the unit does not enforce.
module framed_command_adc_reporter_unit (
	input logic        clk,
	input logic        arst_n,
	fcar_item_if.sink  items,
	fcar_cfg_if.sink   cfg,
	fcar_tx_if.source  reply
);
	import fcar_pkg::*;

	logic        push_valid, push_ready;
	reply_desc_t push_desc;
	logic        pop_valid, pop_ready;
	reply_desc_t pop_desc;

	// Front part: parser, countdown and reply decision.
	fcar_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	// The queue lets the front keep taking items while a reply is going out.
	fcar_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	// Back part: turns a descriptor into its reply bytes.
	fcar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.reply     (reply)
	);
endmodule
